### hdl/bclr_pkg.sv
// bclr_pkg: shared types, opcodes and status codes of the block cache
// used by block_cache_lookup_replace, bclr_way_select and bclr_checker; no dependencies
package bclr_pkg;

  // operation carried by one item
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_UPDATE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // line status codes
  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_QUEUED = 3'd1;
  localparam logic [2:0] ST_READY  = 3'd2;
  localparam logic [2:0] ST_FAILED = 3'd3;
  localparam logic [2:0] ST_OTHER  = 3'd4;

  // eviction priorities, larger goes first
  localparam logic [2:0] PRIO_FAILED = 3'd5;
  localparam logic [2:0] PRIO_NONE   = 3'd4;
  localparam logic [2:0] PRIO_READY  = 3'd3;
  localparam logic [2:0] PRIO_OTHER  = 3'd2;
  localparam logic [2:0] PRIO_QUEUED = 3'd1;

  // hotness seed for the victim search
  localparam logic [7:0] HOT_MAX = 8'hFF;

  // one cache line as stored
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [2:0]  status;
    logic [7:0]  hotness;
  } line_t;

  // map a status code to its eviction priority
  function automatic logic [2:0] evict_prio(input logic [2:0] status);
    logic [2:0] prio;
    unique case (status)
      ST_FAILED: prio = PRIO_FAILED;
      ST_NONE:   prio = PRIO_NONE;
      ST_READY:  prio = PRIO_READY;
      ST_QUEUED: prio = PRIO_QUEUED;
      default:   prio = PRIO_OTHER;
    endcase
    return prio;
  endfunction

endpackage

### hdl/block_cache_lookup_replace.sv
// block_cache_lookup_replace: top level of the set-associative block cache
// depends on bclr_pkg, bclr_set_index, bclr_tag_store and bclr_way_select
//
// Usage:
//   Command channel: an item (opcode, pc, new_status, new_hotness) is taken at a
//   rising edge with start high and busy low. Opcodes: lookup/allocate, update,
//   flush, and an ignored fourth code.
//   Result channel: done is high for one cycle with hit, way_out, set_out, the
//   evicted fields, status_out and hotness_out. The receiver cannot stall, so
//   results are never held back.
//   Pipeline: stage 1 register, stage 2 register with the set row, result
//   register driving done. Throughput: one item per cycle for lookup and
//   update while busy is low; a same-set item right behind another sees its
//   update through a one-entry write bypass.
//   Flush: busy is high while the flush is in stage 1 and stage 2, then during
//   a clearing pass that writes one set row per cycle over all NUM_SETS rows.
//   Reset: rst (synchronous) drops all items in flight and starts the same
//   clearing pass; busy stays high until it ends.
//   Rate is set by the tag store ports: one read and one write a cycle.
module block_cache_lookup_replace #(
  parameter int NUM_SETS = 256,
  parameter int NUM_WAYS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] pc,
  input  logic [2:0]  new_status,
  input  logic [7:0]  new_hotness,
  output logic        done,
  output logic        hit,
  output logic [1:0]  way_out,
  output logic [7:0]  set_out,
  output logic        evicted_valid,
  output logic [31:0] evicted_tag,
  output logic        evicted_queued,
  output logic [2:0]  status_out,
  output logic [7:0]  hotness_out
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ROW_W = NUM_WAYS * $bits(bclr_pkg::line_t);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

  // stage 1: accepted item, set index in progress
  logic               v1;
  bclr_pkg::op_t      op1;
  logic [31:0]        pc1;
  logic [2:0]         st1;
  logic [7:0]         hot1;
  logic [SET_W-1:0]   set1;

  // stage 2: item with its set row
  logic               v2;
  bclr_pkg::op_t      op2;
  logic [31:0]        pc2;
  logic [2:0]         st2;
  logic [7:0]         hot2;
  logic [SET_W-1:0]   set2;

  // clearing pass
  logic               clearing;
  logic [SET_W-1:0]   clr_cnt;

  // write bypass for the item right behind
  logic                                fwd_v;
  logic [SET_W-1:0]                    fwd_set;
  bclr_pkg::line_t [NUM_WAYS-1:0]      fwd_row;

  logic [ROW_W-1:0]                    rd_data;
  bclr_pkg::line_t [NUM_WAYS-1:0]      row_rd;
  bclr_pkg::line_t [NUM_WAYS-1:0]      row_cur;
  bclr_pkg::line_t [NUM_WAYS-1:0]      row_new;
  bclr_pkg::line_t                     victim;
  logic                                line_wr;
  logic                                mem_wr;
  logic [SET_W-1:0]                    mem_addr;
  logic [ROW_W-1:0]                    mem_data;

  logic               sel_hit;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   victim_way;

  logic               accept;
  logic               hit_next;
  logic [1:0]         way_next;
  logic [7:0]         set_next;
  logic               ev_valid_next;
  logic [31:0]        ev_tag_next;
  logic               ev_queued_next;
  logic [2:0]         status_next;
  logic [7:0]         hotness_next;

  // hold off items while flushing or clearing
  assign busy = clearing
             || (v1 && (op1 == bclr_pkg::OP_FLUSH))
             || (v2 && (op2 == bclr_pkg::OP_FLUSH));
  assign accept = start && !busy;

  // stage 1 and stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
    op1  <= bclr_pkg::op_t'(opcode);
    pc1  <= pc;
    st1  <= new_status;
    hot1 <= new_hotness;
    op2  <= op1;
    pc2  <= pc1;
    st2  <= st1;
    hot2 <= hot1;
    set2 <= set1;
  end

  bclr_set_index #(
    .NUM_SETS (NUM_SETS),
    .SET_W    (SET_W)
  ) u_set_index (
    .clk  (clk),
    .addr (pc[31:2]),
    .set  (set1)
  );

  bclr_tag_store #(
    .DEPTH (NUM_SETS),
    .AW    (SET_W),
    .WIDTH (ROW_W)
  ) u_tag_store (
    .clk     (clk),
    .rd_addr (set1),
    .rd_data (rd_data),
    .wr_en   (mem_wr),
    .wr_addr (mem_addr),
    .wr_data (mem_data)
  );

  assign row_rd  = rd_data;
  assign row_cur = (fwd_v && (fwd_set == set2)) ? fwd_row : row_rd;

  bclr_way_select #(
    .NUM_WAYS (NUM_WAYS),
    .WAY_W    (WAY_W)
  ) u_way_select (
    .row        (row_cur),
    .tag        (pc2),
    .hit        (sel_hit),
    .hit_way    (hit_way),
    .victim_way (victim_way)
  );

  // result and row update for the item in stage 2
  always_comb begin
    row_new        = row_cur;
    victim         = row_cur[victim_way];
    line_wr        = 1'b0;
    hit_next       = 1'b0;
    way_next       = '0;
    set_next       = '0;
    ev_valid_next  = 1'b0;
    ev_tag_next    = '0;
    ev_queued_next = 1'b0;
    status_next    = '0;
    hotness_next   = '0;
    unique case (op2)
      bclr_pkg::OP_LOOKUP: begin
        set_next = 8'(set2);
        if (sel_hit) begin
          hit_next     = 1'b1;
          way_next     = 2'(hit_way);
          status_next  = row_cur[hit_way].status;
          hotness_next = row_cur[hit_way].hotness;
        end else begin
          line_wr                     = 1'b1;
          way_next                    = 2'(victim_way);
          ev_valid_next               = victim.valid;
          ev_tag_next                 = victim.valid ? victim.tag : '0;
          ev_queued_next              = victim.valid && (victim.status == bclr_pkg::ST_QUEUED);
          row_new[victim_way].valid   = 1'b1;
          row_new[victim_way].tag     = pc2;
          row_new[victim_way].status  = bclr_pkg::ST_NONE;
          row_new[victim_way].hotness = '0;
        end
      end
      bclr_pkg::OP_UPDATE: begin
        set_next = 8'(set2);
        if (sel_hit) begin
          line_wr                     = 1'b1;
          hit_next                    = 1'b1;
          way_next                    = 2'(hit_way);
          status_next                 = st2;
          hotness_next                = hot2;
          row_new[hit_way].status     = st2;
          row_new[hit_way].hotness    = hot2;
        end
      end
      bclr_pkg::OP_FLUSH: begin
        set_next = '0;
      end
      bclr_pkg::OP_NONE: begin
        set_next = '0;
      end
    endcase
  end

  // tag store write: clearing pass or stage 2 update
  assign mem_wr   = clearing || (v2 && line_wr);
  assign mem_addr = clearing ? clr_cnt : set2;
  assign mem_data = clearing ? '0 : row_new;

  // clearing pass after reset and after a flush
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (v2 && (op2 == bclr_pkg::OP_FLUSH)) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == LAST_SET) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // bypass of the row just written
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_v <= 1'b0;
    end else begin
      fwd_v <= !clearing && v2 && line_wr;
    end
    fwd_set <= set2;
    fwd_row <= row_new;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
    hit            <= hit_next;
    way_out        <= way_next;
    set_out        <= set_next;
    evicted_valid  <= ev_valid_next;
    evicted_tag    <= ev_tag_next;
    evicted_queued <= ev_queued_next;
    status_out     <= status_next;
    hotness_out    <= hotness_next;
  end

endmodule

### hdl/bclr_set_index.sv
// bclr_set_index: set index as (pc >> 2) mod NUM_SETS by reciprocal multiply
// quotient and low address bits registered, remainder formed from them combinationally; no package dependency
module bclr_set_index #(
  parameter int NUM_SETS = 256,
  parameter int SET_W    = 8
) (
  input  logic             clk,
  input  logic [29:0]      addr,
  output logic [SET_W-1:0] set
);

  localparam int CLOG  = $clog2(NUM_SETS);
  localparam int SHIFT = 30 + CLOG;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
  localparam logic [30:0] RECIP = RECIP_FULL[30:0];
  localparam logic [SET_W-1:0] D_LO = SET_W'(NUM_SETS);

  logic [60:0]      prod;
  logic [29:0]      quot;
  logic [SET_W-1:0] addr_lo;

  // exact quotient: addr * ceil(2^SHIFT / NUM_SETS) >> SHIFT
  assign prod = addr * RECIP;

  always_ff @(posedge clk) begin
    quot    <= 30'(prod >> SHIFT);
    addr_lo <= addr[SET_W-1:0];
  end

  // remainder fits in SET_W bits, so only the low product bits matter
  assign set = addr_lo - quot[SET_W-1:0] * D_LO;

endmodule

### hdl/bclr_tag_store.sv
// bclr_tag_store: one row of all ways per set, one write and one registered read port
// generic memory; no package dependency
module bclr_tag_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int WIDTH = 176
) (
  input  logic             clk,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, returns old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/bclr_way_select.sv
// bclr_way_select: tag compare over the ways of one set and victim choice on a miss
// depends on bclr_pkg for line_t and evict_prio
module bclr_way_select #(
  parameter int NUM_WAYS = 4,
  parameter int WAY_W    = 2
) (
  input  bclr_pkg::line_t [NUM_WAYS-1:0] row,
  input  logic [31:0]                    tag,
  output logic                           hit,
  output logic [WAY_W-1:0]               hit_way,
  output logic [WAY_W-1:0]               victim_way
);

  // first valid way with a matching tag
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row[w].valid && (row[w].tag == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // first invalid way, else highest priority, ties to the colder way, the later one on equal hotness
  always_comb begin
    logic       inv_found;
    logic       have;
    logic [2:0] bprio;
    logic [2:0] prio;
    logic [7:0] bhot;
    inv_found  = 1'b0;
    have       = 1'b0;
    bprio      = '0;
    prio       = '0;
    bhot       = bclr_pkg::HOT_MAX;
    victim_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!inv_found) begin
        if (!row[w].valid) begin
          inv_found  = 1'b1;
          victim_way = WAY_W'(w);
        end else begin
          prio = bclr_pkg::evict_prio(row[w].status);
          if (!have || (prio > bprio) || ((prio == bprio) && (row[w].hotness <= bhot))) begin
            have       = 1'b1;
            victim_way = WAY_W'(w);
            bprio      = prio;
            bhot       = row[w].hotness;
          end
        end
      end
    end
  end

endmodule

### hdl/bclr_checker.sv
// bclr_checker: port-level checks on the block cache, bound to the top level
// depends on bclr_pkg for the flush opcode
module bclr_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode,
  input logic        done,
  input logic        hit,
  input logic        evicted_valid,
  input logic [31:0] evicted_tag,
  input logic        evicted_queued
);

  // every accepted item gives a result on done
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted item gave no result");

  // no result without an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without an accepted item");

  // a flush keeps the command side closed while it drains
  a_flush_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == bclr_pkg::OP_FLUSH)) |=> busy ##1 busy)
    else $error("item accepted behind a flush");

  // eviction reports only on misses and stay clean when nothing was evicted
  a_evict_fields: assert property (@(posedge clk) disable iff (rst)
    done |-> ((!evicted_valid || !hit)
           && (evicted_valid || ((evicted_tag == 32'd0) && !evicted_queued))))
    else $error("inconsistent eviction report");

endmodule

bind block_cache_lookup_replace bclr_checker u_bclr_checker (.*);

### verif/tb_block_cache_lookup_replace.sv
// tb_block_cache_lookup_replace: self-checking bench for the block cache
// depends on bclr_pkg and block_cache_lookup_replace; line predictor runs per accepted item
`timescale 1ns / 1ps

module tb_block_cache_lookup_replace;

  localparam int NUM_SETS = 256;
  localparam int NUM_WAYS = 4;
  localparam int POOL = 24;
  localparam int RANDOM_ITEMS = 1300;
  localparam int IDLE_PCT = 38;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  // one command item as driven
  typedef struct {
    bclr_pkg::op_t op;
    logic [31:0]   pc;
    logic [2:0]    status;
    logic [7:0]    hotness;
    bit            eager;
    bit            drain;
  } cmd_t;

  // one result as the block reports it
  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [7:0]  set;
    logic        ev_valid;
    logic [31:0] ev_tag;
    logic        ev_queued;
    logic [2:0]  status;
    logic [7:0]  hotness;
  } cache_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = bclr_pkg::OP_LOOKUP;
  logic [31:0] pc = '0;
  logic [2:0]  new_status = bclr_pkg::ST_NONE;
  logic [7:0]  new_hotness = '0;
  logic        busy;
  logic        done;
  logic        hit;
  logic [1:0]  way_out;
  logic [7:0]  set_out;
  logic        evicted_valid;
  logic [31:0] evicted_tag;
  logic        evicted_queued;
  logic [2:0]  status_out;
  logic [7:0]  hotness_out;

  block_cache_lookup_replace #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .pc(pc),
    .new_status(new_status),
    .new_hotness(new_hotness),
    .done(done),
    .hit(hit),
    .way_out(way_out),
    .set_out(set_out),
    .evicted_valid(evicted_valid),
    .evicted_tag(evicted_tag),
    .evicted_queued(evicted_queued),
    .status_out(status_out),
    .hotness_out(hotness_out)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predicted copy of the cache lines
  bit          line_ok  [NUM_SETS][NUM_WAYS];
  bit [31:0]   line_pc  [NUM_SETS][NUM_WAYS];
  bit [2:0]    line_st  [NUM_SETS][NUM_WAYS];
  bit [7:0]    line_hot [NUM_SETS][NUM_WAYS];

  cmd_t          pending_cmds[$];
  cache_result_t expected_results[$];
  cmd_t          cur;

  logic [31:0] pc_pool[POOL];
  logic [7:0]  set_pool[4];

  int n_taken = 0;
  int n_seen = 0;
  int n_errors = 0;
  int n_lookups = 0;
  int n_hits = 0;
  int n_evicts = 0;
  int n_updates = 0;
  int n_matched = 0;
  int n_flushes = 0;
  int n_ignored = 0;
  int stall_cycles = 0;

  // eviction rank of a line status, larger goes first
  function automatic int victim_rank(logic [2:0] st);
    case (st)
      bclr_pkg::ST_FAILED: return 5;
      bclr_pkg::ST_NONE:   return 4;
      bclr_pkg::ST_READY:  return 3;
      bclr_pkg::ST_QUEUED: return 1;
      default:             return 2;
    endcase
  endfunction

  // apply one item to the predicted lines and return its result
  function automatic cache_result_t cache_access(cmd_t c);
    cache_result_t r;
    logic [7:0] s;
    int w;
    int hw;
    int vw;
    bit found;
    bit have;
    int best_rank;
    int best_hot;
    int rank;
    r = '0;
    s = c.pc[9:2];
    if (c.op == bclr_pkg::OP_FLUSH) begin
      foreach (line_ok[i, j]) begin
        line_ok[i][j] = 1'b0;
        line_pc[i][j] = '0;
        line_st[i][j] = bclr_pkg::ST_NONE;
        line_hot[i][j] = '0;
      end
      return r;
    end
    if (c.op == bclr_pkg::OP_NONE) return r;
    found = 1'b0;
    hw = 0;
    for (w = 0; w < NUM_WAYS; w++) begin
      if (line_ok[s][w] && line_pc[s][w] == c.pc) begin
        found = 1'b1;
        hw = w;
        break;
      end
    end
    r.set = s;
    // update touches only a matching line
    if (c.op == bclr_pkg::OP_UPDATE) begin
      if (found) begin
        line_st[s][hw] = c.status;
        line_hot[s][hw] = c.hotness;
        r.hit = 1'b1;
        r.way = 2'(hw);
        r.status = c.status;
        r.hotness = c.hotness;
      end
      return r;
    end
    if (found) begin
      r.hit = 1'b1;
      r.way = 2'(hw);
      r.status = line_st[s][hw];
      r.hotness = line_hot[s][hw];
      return r;
    end
    // miss: first free way, else best rank with later-way tie break on hotness
    vw = 0;
    have = 1'b0;
    best_rank = 0;
    best_hot = 255;
    for (w = 0; w < NUM_WAYS; w++) begin
      if (!line_ok[s][w]) begin
        vw = w;
        break;
      end
      rank = victim_rank(line_st[s][w]);
      if (!have || rank > best_rank || (rank == best_rank && line_hot[s][w] <= best_hot)) begin
        have = 1'b1;
        vw = w;
        best_rank = rank;
        best_hot = line_hot[s][w];
      end
    end
    if (line_ok[s][vw]) begin
      r.ev_valid = 1'b1;
      r.ev_tag = line_pc[s][vw];
      r.ev_queued = (line_st[s][vw] == bclr_pkg::ST_QUEUED);
    end
    line_ok[s][vw] = 1'b1;
    line_pc[s][vw] = c.pc;
    line_st[s][vw] = bclr_pkg::ST_NONE;
    line_hot[s][vw] = '0;
    r.way = 2'(vw);
    return r;
  endfunction

  task automatic queue_cmd(bclr_pkg::op_t op, logic [31:0] addr, logic [2:0] st,
                           logic [7:0] hot, bit eager, bit drain);
    cmd_t c;
    c.op = op;
    c.pc = addr;
    c.status = st;
    c.hotness = hot;
    c.eager = eager;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  // address in a contended set, random tag bits and low bits
  function automatic logic [31:0] pool_pc(int k);
    return {22'($urandom), set_pool[k % 4], 2'($urandom)};
  endfunction

  // mostly pool traffic so sets fill and evict; the rest is noise
  function automatic cmd_t random_cmd(bit eager, bit drain);
    cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    c.pc = pc_pool[$urandom_range(0, POOL - 1)];
    c.status = 3'($urandom);
    case ($urandom_range(0, 3))
      0: c.hotness = 8'h00;
      1: c.hotness = 8'hFF;
      2: c.hotness = 8'($urandom_range(0, 3));
      default: c.hotness = 8'($urandom);
    endcase
    c.eager = eager;
    c.drain = drain;
    if (roll < 1) begin
      c.op = bclr_pkg::OP_FLUSH;
    end else if (roll < 4) begin
      c.op = bclr_pkg::OP_NONE;
      c.pc = $urandom;
    end else if (roll < 8) begin
      c.op = bclr_pkg::OP_LOOKUP;
      c.pc = $urandom;
    end else if (roll < 13) begin
      c.op = bclr_pkg::OP_UPDATE;
      c.pc = $urandom;
    end else if (roll < 42) begin
      c.op = bclr_pkg::OP_UPDATE;
    end else begin
      c.op = bclr_pkg::OP_LOOKUP;
    end
    return c;
  endfunction

  // driver: present items from the pending queue, idle at random
  always @(posedge clk) begin
    logic took;
    logic go;
    int outstanding;
    cache_result_t r;
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        r = cache_access(cur);
        expected_results.push_back(r);
        n_taken <= n_taken + 1;
        case (cur.op)
          bclr_pkg::OP_LOOKUP: begin
            n_lookups++;
            if (r.hit) n_hits++;
            if (r.ev_valid) n_evicts++;
          end
          bclr_pkg::OP_UPDATE: begin
            n_updates++;
            if (r.hit) n_matched++;
          end
          bclr_pkg::OP_FLUSH: n_flushes++;
          default: n_ignored++;
        endcase
      end
      if (!start || took) begin
        outstanding = n_taken + int'(took) - n_seen - int'(done === 1'b1);
        go = pending_cmds.size() != 0;
        if (go) go = pending_cmds[0].eager || $urandom_range(0, 99) >= IDLE_PCT;
        if (go && pending_cmds[0].drain && outstanding != 0) go = 1'b0;
        if (go) begin
          cur = pending_cmds.pop_front();
          opcode <= cur.op;
          pc <= cur.pc;
          new_status <= cur.status;
          new_hotness <= cur.hotness;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // monitor: every strobed result against the oldest prediction
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && done === 1'b1) begin
      n_seen <= n_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got set %0h way %0h",
                 $time, set_out, way_out);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("hit", want.hit, hit);
        compare_field("way_out", want.way, way_out);
        compare_field("set_out", want.set, set_out);
        compare_field("evicted_valid", want.ev_valid, evicted_valid);
        compare_field("evicted_tag", want.ev_tag, evicted_tag);
        compare_field("evicted_queued", want.ev_queued, evicted_queued);
        compare_field("status_out", want.status, status_out);
        compare_field("hotness_out", want.hotness, hotness_out);
      end
    end
  end

  // watchdog: cycles with no item and no result taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int made;
    cmd_t c;

    // directed: fill set zero, evict by rank, tie break, queued eviction, flush
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'h0000_0000, bclr_pkg::ST_NONE, 8'h00, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'h0000_0000, bclr_pkg::ST_NONE, 8'h00, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_UPDATE, 32'h0000_0000, bclr_pkg::ST_FAILED, 8'hFF, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_UPDATE, 32'hFFFF_FFFF, 3'd7, 8'hFF, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'h0000_0400, bclr_pkg::ST_NONE, 8'h00, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'h0000_0800, bclr_pkg::ST_NONE, 8'h00, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'h0000_0C00, bclr_pkg::ST_NONE, 8'h00, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_UPDATE, 32'h0000_0400, bclr_pkg::ST_QUEUED, 8'd10, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_UPDATE, 32'h0000_0800, bclr_pkg::ST_READY, 8'd5, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_UPDATE, 32'h0000_0C00, 3'd7, 8'd0, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'h0000_1000, bclr_pkg::ST_NONE, 8'h00, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_UPDATE, 32'h0000_1000, bclr_pkg::ST_READY, 8'd5, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_UPDATE, 32'h0000_0C00, bclr_pkg::ST_QUEUED, 8'd0, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'h0000_1400, bclr_pkg::ST_NONE, 8'h00, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_UPDATE, 32'h0000_1000, bclr_pkg::ST_QUEUED, 8'd0, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_UPDATE, 32'h0000_1400, bclr_pkg::ST_QUEUED, 8'd200, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'h0000_1800, bclr_pkg::ST_NONE, 8'h00, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'h0000_1800, bclr_pkg::ST_NONE, 8'h00, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'hFFFF_FFFF, bclr_pkg::ST_OTHER, 8'h00, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_NONE, 32'hFFFF_FFFF, 3'd7, 8'hFF, 1'b0, 1'b0);
    queue_cmd(bclr_pkg::OP_FLUSH, 32'h0000_0000, bclr_pkg::ST_NONE, 8'h00, 1'b0, 1'b1);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'h0000_0000, bclr_pkg::ST_NONE, 8'h00, 1'b1, 1'b0);
    queue_cmd(bclr_pkg::OP_UPDATE, 32'h0000_0000, 3'd6, 8'd1, 1'b1, 1'b0);
    queue_cmd(bclr_pkg::OP_LOOKUP, 32'hFFFF_FFFF, bclr_pkg::ST_NONE, 8'h00, 1'b1, 1'b0);

    // random: contended sets, pool refreshed now and then
    set_pool[0] = 8'h00;
    set_pool[1] = 8'hFF;
    set_pool[2] = 8'($urandom_range(1, 127));
    set_pool[3] = 8'($urandom_range(128, 254));
    for (k = 0; k < POOL; k++) pc_pool[k] = pool_pc(k);
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if (made % 64 == 63) begin
        k = $urandom_range(0, POOL - 1);
        pc_pool[k] = pool_pc(k);
      end
      c = random_cmd(made >= 500 && made < 800, made % 300 == 150);
      pending_cmds.push_back(c);
      if (c.op != bclr_pkg::OP_NONE) made++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // wait for every item taken and every result back, then a short tail
    do @(negedge clk); while (pending_cmds.size() != 0 || start || n_taken != n_seen);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected none left, got %0d",
               $time, expected_results.size(), expected_results.size());
      n_errors++;
    end
    $display("covered %0d lookups (%0d hits, %0d evictions), %0d updates (%0d matched),",
             n_lookups, n_hits, n_evicts, n_updates, n_matched);
    $display("  %0d flushes and %0d ignored opcodes; %0d mismatches",
             n_flushes, n_ignored, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
